// ----- hdl/ibbs_pkg.sv -----
// Package of shared constants, codes and payload types for the bound search unit.
`timescale 1ns / 1ps

package ibbs_pkg;

	// Store geometry.
	localparam int BLOCK_KEYS = 8;
	localparam int CAPACITY   = 4096;
	localparam int KEY_W      = 64;
	localparam int ROWS       = CAPACITY / BLOCK_KEYS;
	localparam int LANE_W     = $clog2(BLOCK_KEYS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int SLOT_W     = 12;
	localparam int COUNT_W    = 13;
	localparam int BLK_W      = $clog2(CAPACITY) + 1;
	localparam int START_W    = BLK_W + LANE_W;
	localparam int HITS_W     = $clog2(BLOCK_KEYS + 1);

	// Configuration port.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = COUNT_W;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_COUNT   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_KEYS = 1'd1;

	// Command codes.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_LOWER = 2'd1;
	localparam logic [1:0] CMD_UPPER = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// Flipping the top bit turns a two's complement order into an unsigned one.
	localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

	typedef struct packed {
		logic [1:0]        command;
		logic [SLOT_W-1:0] slot_address;
		logic [KEY_W-1:0]  key_value;
	} request_t;

	typedef struct packed {
		logic [COUNT_W-1:0] bound_index;
		logic               found;
	} response_t;

endpackage

// ----- hdl/implicit_btree_bound_search_unit.sv -----
// Top level of the bound search unit over keys stored in implicit B-tree order.
//
//  Channel   Signals                          Transfer
//  --------  -------------------------------  ---------------------------------
//  command   start, busy, cmd                 edge with start high and busy low
//  result    done, result                     every edge with done high
//  config    cfg_we, cfg_index, cfg_data      every edge with cfg_we high
//
// A key write leaves busy low. A query visits L blocks (at most four for 4096
// keys); each level is one read of the block-wide key memory followed by one
// eight-lane compare and descend step. An empty store answers without reading
// the key memory. Reset clears the control state and the configuration
// registers; the walk payload registers and the key memory are not cleared.
// The result strobe lasts one cycle and cannot be held off.
`timescale 1ns / 1ps

module implicit_btree_bound_search_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  ibbs_pkg::request_t                  cmd,
	output logic                                done,
	output ibbs_pkg::response_t                 result,
	input  logic                                cfg_we,
	input  logic [ibbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ibbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_CMP  = 3'b100
	} state_t;

	state_t                             state_q;
	logic [ibbs_pkg::COUNT_W-1:0]       key_count_q;
	logic                               signed_keys_q;
	logic [ibbs_pkg::KEY_W-1:0]         query_q;
	logic [ibbs_pkg::KEY_W-1:0]         flip_q;
	logic                               upper_q;
	logic [ibbs_pkg::COUNT_W-1:0]       n_q;
	logic [ibbs_pkg::BLK_W-1:0]         blk_q;
	logic [ibbs_pkg::COUNT_W-1:0]       bound_q;
	logic                               found_q;
	logic                               done_q;
	ibbs_pkg::response_t                result_q;

	logic                               accept;
	logic                               wr_en;
	logic                               rd_en;
	logic [ibbs_pkg::ROW_W-1:0]         wr_row;
	logic [ibbs_pkg::LANE_W-1:0]        wr_lane;
	logic [ibbs_pkg::COUNT_W-1:0]       n_sat;
	logic [ibbs_pkg::KEY_W-1:0]         rd_q [ibbs_pkg::BLOCK_KEYS];

	logic [ibbs_pkg::START_W-1:0]       blk_start;
	logic [ibbs_pkg::COUNT_W-1:0]       remain;
	logic [ibbs_pkg::HITS_W-1:0]        valid_keys;
	logic [ibbs_pkg::BLOCK_KEYS-1:0]    hit;
	logic [ibbs_pkg::HITS_W-1:0]        hits;
	logic                               take;
	logic [ibbs_pkg::COUNT_W-1:0]       bound_next;
	logic [ibbs_pkg::BLK_W-1:0]         blk_next;
	logic [ibbs_pkg::START_W-1:0]       start_next;
	logic                               walk_end;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_en  = accept && (cmd.command == ibbs_pkg::CMD_WRITE)
	                && ({1'b0, cmd.slot_address} < ibbs_pkg::COUNT_W'(ibbs_pkg::CAPACITY));
	assign wr_row  = cmd.slot_address[ibbs_pkg::LANE_W +: ibbs_pkg::ROW_W];
	assign wr_lane = cmd.slot_address[ibbs_pkg::LANE_W-1:0];
	assign rd_en   = (state_q == ST_READ);

	// Valid count saturated to the store capacity.
	assign n_sat = (key_count_q > ibbs_pkg::COUNT_W'(ibbs_pkg::CAPACITY)) ?
	               ibbs_pkg::COUNT_W'(ibbs_pkg::CAPACITY) : key_count_q;

	// One memory per lane, so a whole block is read at once.
	for (genvar lane = 0; lane < ibbs_pkg::BLOCK_KEYS; lane++) begin : g_lane
		logic [ibbs_pkg::KEY_W-1:0] key_mem [ibbs_pkg::ROWS];

		always_ff @(posedge clk) begin
			if (wr_en && (wr_lane == ibbs_pkg::LANE_W'(lane))) begin
				key_mem[wr_row] <= cmd.key_value;
			end
			if (rd_en) begin
				rd_q[lane] <= key_mem[blk_q[ibbs_pkg::ROW_W-1:0]];
			end
		end
	end

	// Compare step: count the valid keys of the block that lie below the query, or at it for an upper-bound search.
	always_comb begin
		blk_start = {blk_q, {ibbs_pkg::LANE_W{1'b0}}};
		remain    = n_q - blk_start[ibbs_pkg::COUNT_W-1:0];
		if (remain >= ibbs_pkg::COUNT_W'(ibbs_pkg::BLOCK_KEYS)) begin
			valid_keys = ibbs_pkg::HITS_W'(ibbs_pkg::BLOCK_KEYS);
		end else begin
			valid_keys = remain[ibbs_pkg::HITS_W-1:0];
		end
		for (int i = 0; i < ibbs_pkg::BLOCK_KEYS; i++) begin
			hit[i] = (ibbs_pkg::COUNT_W'(i) < remain)
			         && (upper_q ? ((rd_q[i] ^ flip_q) <= query_q)
			                     : ((rd_q[i] ^ flip_q) <  query_q));
		end
		hits = '0;
		for (int i = 0; i < ibbs_pkg::BLOCK_KEYS; i++) begin
			hits = hits + ibbs_pkg::HITS_W'(hit[i]);
		end
		take       = (hits < valid_keys);
		bound_next = take ? (blk_start[ibbs_pkg::COUNT_W-1:0] + ibbs_pkg::COUNT_W'(hits))
		                  : bound_q;
		blk_next   = ibbs_pkg::BLK_W'(blk_q * ibbs_pkg::BLK_W'(ibbs_pkg::BLOCK_KEYS + 1))
		             + ibbs_pkg::BLK_W'(1) + ibbs_pkg::BLK_W'(hits);
		start_next = {blk_next, {ibbs_pkg::LANE_W{1'b0}}};
		walk_end   = (start_next >= ibbs_pkg::START_W'(n_q));
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q   <= '0;
			signed_keys_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ibbs_pkg::REG_KEY_COUNT:   key_count_q   <= cfg_data;
				ibbs_pkg::REG_SIGNED_KEYS: signed_keys_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer: one read and one compare per tree level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && ((cmd.command == ibbs_pkg::CMD_LOWER)
					            || (cmd.command == ibbs_pkg::CMD_UPPER))) begin
						if (n_sat == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (walk_end) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					flip_q   <= signed_keys_q ? ibbs_pkg::SIGN_FLIP : '0;
					query_q  <= cmd.key_value ^ (signed_keys_q ? ibbs_pkg::SIGN_FLIP : '0);
					upper_q  <= (cmd.command == ibbs_pkg::CMD_UPPER);
					n_q      <= n_sat;
					blk_q    <= '0;
					bound_q  <= n_sat;
					found_q  <= 1'b0;
					result_q <= '{bound_index: n_sat, found: 1'b0};
				end
			end
			ST_CMP: begin
				bound_q  <= bound_next;
				found_q  <= found_q || take;
				blk_q    <= blk_next;
				result_q <= '{bound_index: bound_next, found: found_q || take};
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
